### rtl/core/pfmt_pkg.sv
`timescale 1ns / 1ps

package pfmt_pkg;

    localparam int MAX_WIDTH = 64;
    localparam int TXT_DEPTH = 12;

    localparam logic [7:0] CH_NUL     = 8'h00;
    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_PERCENT = 8'h25;
    localparam logic [7:0] CH_MINUS   = 8'h2D;
    localparam logic [7:0] CH_ZERO    = 8'h30;
    localparam logic [7:0] CH_NINE    = 8'h39;
    localparam logic [7:0] CH_HEX_LO  = 8'h57;
    localparam logic [7:0] CH_C       = 8'h63;
    localparam logic [7:0] CH_D       = 8'h64;
    localparam logic [7:0] CH_L       = 8'h6C;
    localparam logic [7:0] CH_U       = 8'h75;
    localparam logic [7:0] CH_X       = 8'h78;

    typedef enum logic [2:0] {
        PH_LITERAL,
        PH_PERCENT,
        PH_MINUS,
        PH_ZERO,
        PH_WIDTH,
        PH_LONG
    } phase_t;

    typedef enum logic [3:0] {
        UOP_NOP,
        UOP_ACCEPT,
        UOP_NEG,
        UOP_DIGSET,
        UOP_SUB,
        UOP_DIGIT,
        UOP_PADSET,
        UOP_EMIT_PAD,
        UOP_EMIT_TXT
    } uop_t;

    typedef enum logic [3:0] {
        UC_NEVER,
        UC_ALWAYS,
        UC_DISPATCH,
        UC_NUM_ZERO,
        UC_NUM_GE_DIV,
        UC_MORE_DIV,
        UC_PAD_ZERO,
        UC_PAD_MORE,
        UC_TXT_DONE,
        UC_TXT_MORE
    } ucond_t;

    typedef logic [3:0] upc_t;

    localparam upc_t UA_IDLE    = 4'd0;
    localparam upc_t UA_NEG     = 4'd1;
    localparam upc_t UA_DIGSET  = 4'd2;
    localparam upc_t UA_DLOOP   = 4'd3;
    localparam upc_t UA_DIGIT   = 4'd4;
    localparam upc_t UA_PADSET  = 4'd5;
    localparam upc_t UA_PADTEST = 4'd6;
    localparam upc_t UA_PADOUT  = 4'd7;
    localparam upc_t UA_TXTTEST = 4'd8;
    localparam upc_t UA_TXTOUT  = 4'd9;
    localparam upc_t UA_DONE    = 4'd10;

    typedef struct packed {
        uop_t   op;
        ucond_t cond;
        upc_t   target;
    } uword_t;

    typedef struct packed {
        logic stall;
        upc_t dispatch;
        logic num_zero;
        logic num_ge_div;
        logic more_div;
        logic pad_zero;
        logic pad_more;
        logic txt_done;
        logic txt_more;
    } dp_status_t;

endpackage

### rtl/core/printf_integer_formatter.sv
`timescale 1ns / 1ps

// Integer printf formatter. Send the format string one character per request on
// fmt_char, with the argument word on arg_value (used only by the conversion
// character); the output channel streams the produced characters, with last
// marking the final character caused by a request. Supports %d %u %x %c %%, the
// '-' flag (ignored), the '0' flag, a decimal width saturating at 64 and the 'l'
// length; NUL ends the format. A small microcoded sequencer drives one
// subtract-and-compare datapath, and one request is processed at a time: after
// the request is accepted, %d first negates a negative value and stores the
// sign, then %d, %u and %x clear the digit state and a nonzero value is turned
// into digits one digit position at a time (10 decimal, 8 hex) by repeated
// subtraction; then the padding characters are emitted, followed by the text
// characters. The longest request is %64x of ffffffff. Output backpressure
// stalls the sequencer.
module printf_integer_formatter
    import pfmt_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  fmt_char,
    input  logic [31:0] arg_value,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [7:0]  out_char,
    output logic        last
);

    uop_t       op;
    dp_status_t status;

    pfmt_sequencer u_sequencer (
        .clk    (clk),
        .rst_n  (rst_n),
        .status (status),
        .op     (op)
    );

    pfmt_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .op        (op),
        .status    (status),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .fmt_char  (fmt_char),
        .arg_value (arg_value),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_char  (out_char),
        .last      (last)
    );

endmodule

### rtl/core/pfmt_sequencer.sv
`timescale 1ns / 1ps

module pfmt_sequencer
    import pfmt_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  dp_status_t status,
    output uop_t       op
);

    function automatic uword_t ucode_rom(input upc_t addr);
        uword_t w;
        begin
            case (addr)
                UA_IDLE:    w = '{UOP_ACCEPT,   UC_DISPATCH,   UA_IDLE};
                UA_NEG:     w = '{UOP_NEG,      UC_NEVER,      UA_IDLE};
                UA_DIGSET:  w = '{UOP_DIGSET,   UC_NUM_ZERO,   UA_PADSET};
                UA_DLOOP:   w = '{UOP_SUB,      UC_NUM_GE_DIV, UA_DLOOP};
                UA_DIGIT:   w = '{UOP_DIGIT,    UC_MORE_DIV,   UA_DLOOP};
                UA_PADSET:  w = '{UOP_PADSET,   UC_NEVER,      UA_IDLE};
                UA_PADTEST: w = '{UOP_NOP,      UC_PAD_ZERO,   UA_TXTTEST};
                UA_PADOUT:  w = '{UOP_EMIT_PAD, UC_PAD_MORE,   UA_PADOUT};
                UA_TXTTEST: w = '{UOP_NOP,      UC_TXT_DONE,   UA_IDLE};
                UA_TXTOUT:  w = '{UOP_EMIT_TXT, UC_TXT_MORE,   UA_TXTOUT};
                UA_DONE:    w = '{UOP_NOP,      UC_ALWAYS,     UA_IDLE};
                default:    w = '{UOP_NOP,      UC_ALWAYS,     UA_IDLE};
            endcase
            return w;
        end
    endfunction

    upc_t   upc_reg;
    upc_t   upc_next;
    uword_t uword;
    logic   taken;

    assign uword = ucode_rom(upc_reg);
    assign op    = uword.op;

    always_comb
    begin
        case (uword.cond)
            UC_NEVER:      taken = 1'b0;
            UC_ALWAYS:     taken = 1'b1;
            UC_NUM_ZERO:   taken = status.num_zero;
            UC_NUM_GE_DIV: taken = status.num_ge_div;
            UC_MORE_DIV:   taken = status.more_div;
            UC_PAD_ZERO:   taken = status.pad_zero;
            UC_PAD_MORE:   taken = status.pad_more;
            UC_TXT_DONE:   taken = status.txt_done;
            UC_TXT_MORE:   taken = status.txt_more;
            default:       taken = 1'b0;
        endcase
    end

    always_comb
    begin
        if (status.stall)
        begin
            upc_next = upc_reg;
        end
        else if (uword.cond == UC_DISPATCH)
        begin
            upc_next = status.dispatch;
        end
        else if (taken)
        begin
            upc_next = uword.target;
        end
        else
        begin
            upc_next = upc_reg + 4'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            upc_reg <= UA_IDLE;
        end
        else
        begin
            upc_reg <= upc_next;
        end
    end

endmodule

### rtl/core/pfmt_datapath.sv
`timescale 1ns / 1ps

module pfmt_datapath
    import pfmt_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  uop_t        op,
    output dp_status_t  status,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  fmt_char,
    input  logic [31:0] arg_value,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [7:0]  out_char,
    output logic        last
);

    function automatic logic [31:0] div_value(input logic hex, input logic [3:0] idx);
        logic [31:0] v;
        begin
            if (hex)
            begin
                v = 32'h1000_0000 >> {idx[2:0], 2'b00};
            end
            else
            begin
                case (idx)
                    4'd0:    v = 32'd1000000000;
                    4'd1:    v = 32'd100000000;
                    4'd2:    v = 32'd10000000;
                    4'd3:    v = 32'd1000000;
                    4'd4:    v = 32'd100000;
                    4'd5:    v = 32'd10000;
                    4'd6:    v = 32'd1000;
                    4'd7:    v = 32'd100;
                    4'd8:    v = 32'd10;
                    default: v = 32'd1;
                endcase
            end
            return v;
        end
    endfunction

    phase_t      phase_reg, phase_next;
    logic        zero_pad_reg, zero_pad_next;
    logic [6:0]  field_width_reg, field_width_next;
    logic [31:0] num_reg, num_next;
    logic        hex_reg, hex_next;
    logic [3:0]  idx_reg, idx_next;
    logic [3:0]  dgt_reg, dgt_next;
    logic        started_reg, started_next;
    logic [3:0]  len_reg, len_next;
    logic [3:0]  rd_reg, rd_next;
    logic [6:0]  pad_reg, pad_next;
    logic [7:0]  pad_char_reg, pad_char_next;
    logic        out_valid_reg, out_valid_next;
    logic [7:0]  out_char_reg, out_char_next;
    logic        last_reg, last_next;

    logic [7:0]  txt_mem [TXT_DEPTH];
    logic        txt_we;
    logic [3:0]  txt_waddr;
    logic [7:0]  txt_wdata;
    logic [7:0]  txt_rdata_reg;

    phase_t      p_phase;
    logic        p_zero_pad;
    logic [6:0]  p_width;
    upc_t        p_dispatch;
    logic        p_single;
    logic [7:0]  p_single_char;
    logic        p_conv;
    logic        is_digit;
    logic [9:0]  wsum;
    logic [6:0]  wsat;

    logic [31:0] div_val;
    logic        out_busy;
    logic        stall;
    logic        go;
    logic [7:0]  digit_char;

    assign div_val    = div_value(hex_reg, idx_reg);
    assign out_busy   = out_valid_reg && !out_ready;
    assign digit_char = (dgt_reg < 4'd10) ? (CH_ZERO + {4'b0000, dgt_reg})
                                          : (CH_HEX_LO + {4'b0000, dgt_reg});

    assign is_digit = fmt_char inside {[CH_ZERO:CH_NINE]};
    assign wsum     = 10'(field_width_reg) * 10'd10 + 10'(fmt_char - CH_ZERO);
    assign wsat     = (wsum > 10'(MAX_WIDTH)) ? 7'(MAX_WIDTH) : wsum[6:0];

    always_comb
    begin
        case (op)
            UOP_ACCEPT:   stall = !in_valid;
            UOP_EMIT_PAD: stall = out_busy;
            UOP_EMIT_TXT: stall = out_busy;
            default:      stall = 1'b0;
        endcase
    end

    assign go       = !stall;
    assign in_ready = (op == UOP_ACCEPT);

    // format parse on the incoming character
    always_comb
    begin
        p_phase       = phase_reg;
        p_zero_pad    = zero_pad_reg;
        p_width       = field_width_reg;
        p_dispatch    = UA_IDLE;
        p_single      = 1'b0;
        p_single_char = fmt_char;
        p_conv        = 1'b0;
        if (fmt_char == CH_NUL)
        begin
            p_phase    = PH_LITERAL;
            p_zero_pad = 1'b0;
            p_width    = 7'd0;
        end
        else
        begin
            case (phase_reg)
                PH_PERCENT, PH_MINUS, PH_ZERO, PH_WIDTH:
                begin
                    if (phase_reg == PH_PERCENT && fmt_char == CH_MINUS)
                    begin
                        p_phase = PH_MINUS;
                    end
                    else if ((phase_reg == PH_PERCENT || phase_reg == PH_MINUS)
                             && fmt_char == CH_ZERO)
                    begin
                        p_zero_pad = 1'b1;
                        p_phase    = PH_ZERO;
                    end
                    else if (is_digit)
                    begin
                        p_width = wsat;
                        p_phase = PH_WIDTH;
                    end
                    else if (fmt_char == CH_L)
                    begin
                        p_phase = PH_LONG;
                    end
                    else
                    begin
                        p_conv = 1'b1;
                    end
                end
                PH_LONG:
                begin
                    p_conv = 1'b1;
                end
                default:
                begin
                    if (fmt_char == CH_PERCENT)
                    begin
                        p_phase    = PH_PERCENT;
                        p_zero_pad = 1'b0;
                        p_width    = 7'd0;
                    end
                    else
                    begin
                        p_phase    = PH_LITERAL;
                        p_single   = 1'b1;
                        p_dispatch = UA_PADSET;
                    end
                end
            endcase
            if (p_conv)
            begin
                p_phase = PH_LITERAL;
                case (fmt_char)
                    CH_D:
                    begin
                        p_dispatch = UA_NEG;
                    end
                    CH_U, CH_X:
                    begin
                        p_dispatch = UA_DIGSET;
                    end
                    CH_C:
                    begin
                        p_single      = 1'b1;
                        p_single_char = arg_value[7:0];
                        p_dispatch    = UA_PADSET;
                    end
                    CH_PERCENT:
                    begin
                        p_single   = 1'b1;
                        p_dispatch = UA_PADSET;
                    end
                    default:
                    begin
                        // unknown conversion: padding only
                        p_dispatch = UA_PADSET;
                    end
                endcase
            end
        end
    end

    always_comb
    begin
        phase_next       = phase_reg;
        zero_pad_next    = zero_pad_reg;
        field_width_next = field_width_reg;
        num_next         = num_reg;
        hex_next         = hex_reg;
        idx_next         = idx_reg;
        dgt_next         = dgt_reg;
        started_next     = started_reg;
        len_next         = len_reg;
        rd_next          = rd_reg;
        pad_next         = pad_reg;
        pad_char_next    = pad_char_reg;
        txt_we           = 1'b0;
        txt_waddr        = len_reg;
        txt_wdata        = digit_char;
        out_valid_next   = out_valid_reg && !out_ready;
        out_char_next    = out_char_reg;
        last_next        = last_reg;

        if (go)
        begin
            case (op)
                UOP_ACCEPT:
                begin
                    phase_next       = p_phase;
                    zero_pad_next    = p_zero_pad;
                    field_width_next = p_width;
                    num_next         = arg_value;
                    hex_next         = (fmt_char == CH_X);
                    len_next         = p_single ? 4'd1 : 4'd0;
                    txt_we           = p_single;
                    txt_waddr        = 4'd0;
                    txt_wdata        = p_single_char;
                end
                UOP_NEG:
                begin
                    if (num_reg[31])
                    begin
                        txt_we    = 1'b1;
                        txt_wdata = CH_MINUS;
                        len_next  = len_reg + 4'd1;
                        num_next  = 32'd0 - num_reg;
                    end
                end
                UOP_DIGSET:
                begin
                    idx_next     = 4'd0;
                    dgt_next     = 4'd0;
                    started_next = 1'b0;
                    if (num_reg == 32'd0)
                    begin
                        txt_we    = 1'b1;
                        txt_wdata = CH_ZERO;
                        len_next  = len_reg + 4'd1;
                    end
                end
                UOP_SUB:
                begin
                    if (num_reg >= div_val)
                    begin
                        num_next = num_reg - div_val;
                        dgt_next = dgt_reg + 4'd1;
                    end
                end
                UOP_DIGIT:
                begin
                    if (started_reg || dgt_reg != 4'd0)
                    begin
                        txt_we       = 1'b1;
                        len_next     = len_reg + 4'd1;
                        started_next = 1'b1;
                    end
                    dgt_next = 4'd0;
                    idx_next = idx_reg + 4'd1;
                end
                UOP_PADSET:
                begin
                    pad_next         = (field_width_reg > 7'(len_reg))
                                     ? field_width_reg - 7'(len_reg) : 7'd0;
                    pad_char_next    = zero_pad_reg ? CH_ZERO : CH_SPACE;
                    rd_next          = 4'd0;
                    zero_pad_next    = 1'b0;
                    field_width_next = 7'd0;
                end
                UOP_EMIT_PAD:
                begin
                    out_valid_next = 1'b1;
                    out_char_next  = pad_char_reg;
                    last_next      = (pad_reg == 7'd1) && (len_reg == 4'd0);
                    pad_next       = pad_reg - 7'd1;
                end
                UOP_EMIT_TXT:
                begin
                    out_valid_next = 1'b1;
                    out_char_next  = txt_rdata_reg;
                    last_next      = (rd_reg + 4'd1) == len_reg;
                    rd_next        = rd_reg + 4'd1;
                end
                default:
                begin
                end
            endcase
        end
    end

    // the read address is rd_next, so txt_rdata_reg holds entry rd_reg
    always_ff @(posedge clk)
    begin
        if (txt_we)
        begin
            txt_mem[txt_waddr] <= txt_wdata;
        end
        txt_rdata_reg <= txt_mem[rd_next];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg       <= PH_LITERAL;
            zero_pad_reg    <= 1'b0;
            field_width_reg <= 7'd0;
            idx_reg         <= 4'd0;
            len_reg         <= 4'd0;
            rd_reg          <= 4'd0;
            pad_reg         <= 7'd0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            phase_reg       <= phase_next;
            zero_pad_reg    <= zero_pad_next;
            field_width_reg <= field_width_next;
            idx_reg         <= idx_next;
            len_reg         <= len_next;
            rd_reg          <= rd_next;
            pad_reg         <= pad_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        num_reg      <= num_next;
        hex_reg      <= hex_next;
        dgt_reg      <= dgt_next;
        started_reg  <= started_next;
        pad_char_reg <= pad_char_next;
        out_char_reg <= out_char_next;
        last_reg     <= last_next;
    end

    assign status.stall      = stall;
    assign status.dispatch   = p_dispatch;
    assign status.num_zero   = (num_reg == 32'd0);
    assign status.num_ge_div = (num_reg >= div_val);
    assign status.more_div   = hex_reg ? (idx_reg != 4'd7) : (idx_reg != 4'd9);
    assign status.pad_zero   = (pad_reg == 7'd0);
    assign status.pad_more   = (pad_reg != 7'd1);
    assign status.txt_done   = (rd_reg == len_reg);
    assign status.txt_more   = (rd_reg + 4'd1) != len_reg;

    assign out_valid = out_valid_reg;
    assign out_char  = out_char_reg;
    assign last      = last_reg;

`ifndef SYNTHESIS
    a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
        len_reg <= 4'd11)
        else $error("text length overflow");

    a_width_sat: assert property (@(posedge clk) disable iff (!rst_n)
        field_width_reg <= 7'(MAX_WIDTH))
        else $error("field width above saturation");

    a_pad_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (op == UOP_EMIT_PAD && go) |-> pad_reg != 7'd0)
        else $error("pad emitted with zero count");

    a_txt_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (op == UOP_EMIT_TXT && go) |-> rd_reg < len_reg)
        else $error("text read beyond length");

    a_idle_spec_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (op == UOP_ACCEPT && phase_reg == PH_LITERAL)
        |-> (field_width_reg == 7'd0 && !zero_pad_reg))
        else $error("literal phase with stale spec");
`endif

endmodule

### dv/fmt_output_checker.sv
`timescale 1ns / 1ps

module fmt_output_checker
    import pfmt_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_ready,
    input  logic [7:0]  fmt_char,
    input  logic [31:0] arg_value,
    input  logic        out_valid,
    input  logic        out_ready,
    input  logic [7:0]  out_char,
    input  logic        last,
    output int          errors,
    output int          pending
);

    typedef struct {
        logic [7:0] ch;
        logic       is_last;
    } fmt_out_t;

    phase_t     phase;
    logic       zero_pad;
    logic [6:0] field_width;
    fmt_out_t   expected_chars[$];

    function automatic void clear_spec();
        phase       = PH_LITERAL;
        zero_pad    = 1'b0;
        field_width = '0;
    endfunction

    task automatic emit_char(input logic [7:0] c, input logic is_last);
        fmt_out_t item;
        item.ch      = c;
        item.is_last = is_last;
        expected_chars.push_back(item);
    endtask

    // padding first, then the text (sign included)
    task automatic format_conversion(input logic [7:0] c, input logic [31:0] a);
        logic [7:0]  txt[$];
        logic [7:0]  digits[$];
        logic [31:0] num;
        logic [31:0] dgt;
        logic [31:0] base;
        int          pad;
        int          total;
        base = 32'd0;
        num  = a;
        if (c == CH_D) begin
            base = 32'd10;
            if (a[31]) begin
                txt.push_back(CH_MINUS);
                num = 32'd0 - a;
            end
        end else if (c == CH_U) begin
            base = 32'd10;
        end else if (c == CH_X) begin
            base = 32'd16;
        end else if (c == CH_C) begin
            txt.push_back(a[7:0]);
        end else if (c == CH_PERCENT) begin
            txt.push_back(CH_PERCENT);
        end
        if (base != 32'd0) begin
            do
            begin
                dgt = num % base;
                digits.push_front(dgt < 10 ? CH_ZERO + dgt[7:0] : CH_HEX_LO + dgt[7:0]);
                num = num / base;
            end
            while (num != 32'd0);
            txt = {txt, digits};
        end
        pad   = int'(field_width) > txt.size() ? int'(field_width) - txt.size() : 0;
        total = pad + txt.size();
        for (int k = 0; k < pad; k++)
            emit_char(zero_pad ? CH_ZERO : CH_SPACE, k == total - 1);
        for (int k = 0; k < txt.size(); k++)
            emit_char(txt[k], pad + k == total - 1);
        clear_spec();
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        int       w;
        fmt_out_t exp_item;
        if (!rst_n)
        begin
            clear_spec();
            expected_chars.delete();
            errors  = 0;
            pending = 0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                if (fmt_char == CH_NUL)
                begin
                    clear_spec();
                end
                else
                begin
                    case (phase)
                        PH_PERCENT, PH_MINUS, PH_ZERO, PH_WIDTH:
                        begin
                            if (phase == PH_PERCENT && fmt_char == CH_MINUS)
                            begin
                                phase = PH_MINUS;
                            end
                            else if ((phase == PH_PERCENT || phase == PH_MINUS)
                                     && fmt_char == CH_ZERO)
                            begin
                                zero_pad = 1'b1;
                                phase    = PH_ZERO;
                            end
                            else if (fmt_char >= CH_ZERO && fmt_char <= CH_NINE)
                            begin
                                w = int'(field_width) * 10 + int'(fmt_char) - int'(CH_ZERO);
                                if (w > MAX_WIDTH)
                                    w = MAX_WIDTH;
                                field_width = 7'(w);
                                phase       = PH_WIDTH;
                            end
                            else if (fmt_char == CH_L)
                            begin
                                phase = PH_LONG;
                            end
                            else
                            begin
                                format_conversion(fmt_char, arg_value);
                            end
                        end
                        PH_LONG:
                        begin
                            format_conversion(fmt_char, arg_value);
                        end
                        default:
                        begin
                            if (fmt_char == CH_PERCENT)
                            begin
                                phase       = PH_PERCENT;
                                zero_pad    = 1'b0;
                                field_width = '0;
                            end
                            else
                            begin
                                phase = PH_LITERAL;
                                emit_char(fmt_char, 1'b1);
                            end
                        end
                    endcase
                end
            end
            if (out_valid && out_ready)
            begin
                if (expected_chars.size() == 0)
                begin
                    errors++;
                    if (errors <= 10)
                        $display("%0t: unexpected char %h last %b", $realtime, out_char, last);
                end
                else
                begin
                    exp_item = expected_chars.pop_front();
                    if (exp_item.ch !== out_char || exp_item.is_last !== last)
                    begin
                        errors++;
                        if (errors <= 10)
                            $display("%0t: char mismatch: expected %h last %b, got %h last %b",
                                     $realtime, exp_item.ch, exp_item.is_last, out_char, last);
                    end
                end
            end
            pending = expected_chars.size();
        end
    end

endmodule

### dv/tb.sv
`timescale 1ns / 1ps

module tb;
    import pfmt_pkg::*;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [7:0]  fmt_char;
    logic [31:0] arg_value;
    logic        out_valid;
    logic        out_ready;
    logic [7:0]  out_char;
    logic        last;
    int          errors;
    int          pending;
    int          gap_max;
    int          random_sent;

    printf_integer_formatter dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .fmt_char  (fmt_char),
        .arg_value (arg_value),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_char  (out_char),
        .last      (last)
    );

    fmt_output_checker fmt_chk (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .fmt_char  (fmt_char),
        .arg_value (arg_value),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_char  (out_char),
        .last      (last),
        .errors    (errors),
        .pending   (pending)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    initial
    begin
        #(10_000_000);
        $display("printf_integer_formatter test failed");
        $finish;
    end

    // called at a falling edge, returns at the falling edge after acceptance
    task automatic send_char(input logic [7:0] c, input logic [31:0] a);
        int gap;
        gap = $urandom_range(0, gap_max);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid  <= 1'b1;
        fmt_char  <= c;
        arg_value <= a;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        @(negedge clk);
        random_sent++;
    endtask

    task automatic send_text(input string s, input logic [31:0] a);
        for (int i = 0; i < s.len(); i++)
            send_char(s[i], a);
    endtask

    function automatic logic [31:0] pick_arg();
        case ($urandom_range(0, 5))
            0: return $urandom_range(0, 99);
            1:
            begin
                case ($urandom_range(0, 3))
                    0: return 32'h0000_0000;
                    1: return 32'hFFFF_FFFF;
                    2: return 32'h8000_0000;
                    default: return 32'h7FFF_FFFF;
                endcase
            end
            2: return 32'd0 - $urandom_range(1, 1000);
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [7:0] pick_conv();
        case ($urandom_range(0, 11))
            0, 1, 2: return CH_D;
            3, 4:    return CH_U;
            5, 6:    return CH_X;
            7:       return CH_C;
            8:       return CH_PERCENT;
            9:       return 8'h73;
            10:      return CH_MINUS;
            default: return 8'($urandom_range(1, 255));
        endcase
    endfunction

    // '%' with random flags, width and 'l' length; the conversion itself is left to the caller
    task automatic send_spec_head();
        send_char(CH_PERCENT, $urandom);
        if ($urandom_range(0, 3) == 0)
            send_char(CH_MINUS, $urandom);
        if ($urandom_range(0, 1) == 0)
            send_char(CH_ZERO, $urandom);
        case ($urandom_range(0, 9))
            0, 1, 2: ;
            3, 4, 5, 6, 7: send_char(CH_ZERO + 8'($urandom_range(0, 9)), $urandom);
            8:
            begin
                send_char(CH_ZERO + 8'($urandom_range(1, 2)), $urandom);
                send_char(CH_ZERO + 8'($urandom_range(0, 9)), $urandom);
            end
            default:
            begin
                send_char(CH_ZERO + 8'($urandom_range(1, 9)), $urandom);
                send_char(CH_ZERO + 8'($urandom_range(0, 9)), $urandom);
                if ($urandom_range(0, 1) == 0)
                    send_char(CH_ZERO + 8'($urandom_range(0, 9)), $urandom);
            end
        endcase
        if ($urandom_range(0, 3) == 0)
            send_char(CH_L, $urandom);
    endtask

    initial
    begin
        out_ready = 1'b0;
        wait (rst_n === 1'b1);
        @(negedge clk);
        forever
        begin
            int gap;
            gap = $urandom_range(0, gap_max);
            if (gap > 0)
            begin
                out_ready <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            out_ready <= 1'b1;
            @(posedge clk);
            while (!out_valid)
                @(posedge clk);
            @(negedge clk);
        end
    end

    initial
    begin
        rst_n       = 1'b0;
        in_valid    = 1'b0;
        fmt_char    = '0;
        arg_value   = '0;
        gap_max     = 15;
        random_sent = 0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        send_char(8'hFF, $urandom);
        send_text("A%d", 32'h8000_0000);
        send_text("%099x", 32'hFFFF_FFFF);
        send_text("%-5lu", 32'h0000_0000);
        send_text("%c", 32'h0000_0100);
        send_text("%%", 32'h0000_0000);
        send_text("%s", 32'hFFFF_FFFF);
        send_text("%--", 32'h0000_0000);
        send_text("%ll", 32'h0000_0000);
        send_text("%3", 32'h0000_0000);
        send_char(CH_NUL, $urandom);
        send_text("z", 32'h0000_0000);

        random_sent = 0;
        while (random_sent < 200)
        begin
            if ($urandom_range(0, 7) == 0)
            begin
                case ($urandom_range(0, 2))
                    0: gap_max = 0;
                    1: gap_max = 3;
                    default: gap_max = 15;
                endcase
            end
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4, 5:
                begin
                    send_spec_head();
                    send_char(pick_conv(), pick_arg());
                end
                6, 7:
                begin
                    repeat ($urandom_range(1, 4))
                        send_char(8'($urandom_range(1, 255)), $urandom);
                end
                8:
                begin
                    send_char(8'($urandom_range(0, 255)), pick_arg());
                end
                default:
                begin
                    send_spec_head();
                    send_char(CH_NUL, $urandom);
                end
            endcase
        end

        in_valid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (200) @(negedge clk);
        if (errors == 0 && pending == 0)
            $display("printf_integer_formatter test passed");
        else
            $display("printf_integer_formatter test failed");
        $finish;
    end

endmodule

### filelist.f
rtl/core/pfmt_pkg.sv
rtl/core/pfmt_sequencer.sv
rtl/core/pfmt_datapath.sv
rtl/core/printf_integer_formatter.sv
dv/fmt_output_checker.sv
dv/tb.sv
